>>> rtl/core/kse_pkg.sv
// ============================================================================
// kse_pkg: shared types and constants of the keypad entry block
// Holds the scan phase encoding, the item and result layouts, register
// indexes and the hexadecimal seven-segment table.
// ============================================================================
package kse_pkg;

   localparam int DIGITS_DEFAULT = 8;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [7:0] DEBOUNCE_RESET = 8'd10;
   localparam logic [7:0] DIGIT_RESET    = 8'd2;
   localparam logic [3:0] COL_IDLE       = 4'hf;

   // Configuration register indexes.
   localparam logic CSR_DEBOUNCE_TICKS = 1'b0;
   localparam logic CSR_DIGIT_TICKS    = 1'b1;

   typedef enum logic [6:0] {
      PH_IDLE      = 7'b0000001,
      PH_PRESS_DEB = 7'b0000010,
      PH_CONFIRM   = 7'b0000100,
      PH_SCAN      = 7'b0001000,
      PH_WAIT_REL  = 7'b0010000,
      PH_REL_DEB   = 7'b0100000,
      PH_WAIT_REL2 = 7'b1000000
   } phase_type;

   // Classified column sample passed from the front to the back.
   typedef struct packed {
      logic       any_low;
      logic       single_low;
      logic [1:0] col_idx;
   } col_class_type;

   localparam int CLASS_W = $bits(col_class_type);

   // One result item.
   typedef struct packed {
      logic [3:0] row_drive;
      logic [7:0] digit_select;
      logic [7:0] segments;
      logic       key_valid;
      logic [3:0] key_value;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

   // Configuration write group.
   typedef struct packed {
      logic       en;
      logic       index;
      logic [7:0] data;
   } csr_wr_type;

   function automatic logic [7:0] seg_code(input logic [3:0] key);
      logic [7:0] code;
      case (key)
         4'h0: code = 8'h3f;
         4'h1: code = 8'h06;
         4'h2: code = 8'h5b;
         4'h3: code = 8'h4f;
         4'h4: code = 8'h66;
         4'h5: code = 8'h6d;
         4'h6: code = 8'h7d;
         4'h7: code = 8'h07;
         4'h8: code = 8'h7f;
         4'h9: code = 8'h6f;
         4'ha: code = 8'h77;
         4'hb: code = 8'h7c;
         4'hc: code = 8'h39;
         4'hd: code = 8'h5e;
         4'he: code = 8'h79;
         4'hf: code = 8'h71;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/keypad_scan_seven_segment_entry.sv
// ============================================================================
// keypad_scan_seven_segment_entry: 4x4 keypad scanner with entry display
// Debounces and scans a 4x4 keypad from 1 ms column samples and shows the
// entered hexadecimal keys on a multiplexed eight-digit display.
// ============================================================================
// Usage:
// Each input item is one 1 ms tick that carries the sampled keypad columns
// (active low). Push it with req_push while req_full is low. Every item
// yields exactly one result item, read from the rsp_ side like a FIFO:
// while rsp_empty is low the oldest result is on the rsp_ ports and rsp_pop
// takes it. A result carries the row drive for the keypad, the lit digit's
// select and segment pattern, and a key report when a key was released.
// The front classifies samples into a four-entry queue; the back executes
// one sample per cycle while the result queue has room and writes it into
// a four-entry result queue that feeds the ports. One item per cycle is
// sustained while the receiver pops every cycle. When the receiver stalls,
// the result queue fills, then the sample queue, and req_full rises.
// Reset clears both queues, puts the scanner in its idle phase, blanks the
// display buffer and sets debounce_ticks to 10 and digit_ticks to 2.
// The user writes registers through csr_ only while the block is idle;
// the block itself does not enforce this.
// ============================================================================
module keypad_scan_seven_segment_entry #(
   parameter int DIGITS = kse_pkg::DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // Sample channel.
   input  logic       req_push,
   input  logic [3:0] req_col_lines,
   output logic       req_full,
   // Result channel.
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [3:0] rsp_row_drive,
   output logic [7:0] rsp_digit_select,
   output logic [7:0] rsp_segments,
   output logic       rsp_key_valid,
   output logic [3:0] rsp_key_value,
   // Configuration write port.
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   import kse_pkg::*;

   col_class_type cls_item;
   logic          cls_empty;
   logic          cls_pop;
   rsp_type       rsp_item;
   csr_wr_type    csr_wr;

   assign csr_wr.en    = csr_wr_en;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_wdata;

   // Front: accepts and classifies column samples.
   kse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_col_lines (req_col_lines),
      .req_full      (req_full),
      .cls_pop       (cls_pop),
      .cls_item      (cls_item),
      .cls_empty     (cls_empty)
   );

   // Back: scan sequencer, entry buffer and display multiplexer.
   kse_back #(
      .DIGITS (DIGITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr    (csr_wr),
      .cls_item  (cls_item),
      .cls_empty (cls_empty),
      .cls_pop   (cls_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_row_drive    = rsp_item.row_drive;
   assign rsp_digit_select = rsp_item.digit_select;
   assign rsp_segments     = rsp_item.segments;
   assign rsp_key_valid    = rsp_item.key_valid;
   assign rsp_key_value    = rsp_item.key_value;

endmodule

>>> rtl/core/kse_queue.sv
// ============================================================================
// kse_queue: small synchronous FIFO
// A register-file queue with full and empty flags; a push into a full
// queue and a pop from an empty one are ignored.
// ============================================================================
module kse_queue #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/core/kse_front.sv
// ============================================================================
// kse_front: input side of the keypad entry block
// Accepts column samples, classifies them and queues them for the back.
// ============================================================================
module kse_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic [3:0]            req_col_lines,
   output logic                  req_full,
   input  logic                  cls_pop,
   output kse_pkg::col_class_type cls_item,
   output logic                  cls_empty
);

   import kse_pkg::*;

   col_class_type    cls_new;
   logic [3:0]       low_bits;
   logic [CLASS_W-1:0] cls_bits;

   // A column that reads 0 is pulled low by a pressed key.
   assign low_bits = ~req_col_lines;

   always_comb begin
      cls_new.any_low    = (req_col_lines != COL_IDLE);
      cls_new.single_low = $onehot(low_bits);
      cls_new.col_idx    = 2'd0;
      case (low_bits)
         4'b0010: cls_new.col_idx = 2'd1;
         4'b0100: cls_new.col_idx = 2'd2;
         4'b1000: cls_new.col_idx = 2'd3;
         default: cls_new.col_idx = 2'd0;
      endcase
   end

   kse_queue #(
      .WIDTH (CLASS_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cls_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (cls_new),
      .full  (req_full),
      .pop   (cls_pop),
      .rdata (cls_bits),
      .empty (cls_empty)
   );

   assign cls_item = col_class_type'(cls_bits);

endmodule

>>> rtl/core/kse_back.sv
// ============================================================================
// kse_back: scan sequencer and display multiplexer
// Steps the keypad scan and the digit multiplexing once per sample and
// queues one result item for every sample.
// ============================================================================
module kse_back #(
   parameter int DIGITS = kse_pkg::DIGITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kse_pkg::csr_wr_type    csr_wr,
   input  kse_pkg::col_class_type cls_item,
   input  logic                   cls_empty,
   output logic                   cls_pop,
   output kse_pkg::rsp_type       rsp_item,
   output logic                   rsp_empty,
   input  logic                   rsp_pop
);

   import kse_pkg::*;

   localparam int LIT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int CNT_W = $clog2(DIGITS + 1);

   logic [7:0]       debounce_ticks_ff;
   logic [7:0]       digit_ticks_ff;
   phase_type        phase_ff, phase_in;
   logic [1:0]       scan_row_ff, scan_row_in;
   logic [7:0]       deb_count_ff, deb_count_in;
   logic             cap_single_ff, cap_single_in;
   logic [1:0]       cap_idx_ff, cap_idx_in;
   logic [7:0]       digit_buf_ff [DIGITS];
   logic [CNT_W-1:0] entry_count_ff;
   logic [LIT_W-1:0] lit_digit_ff, lit_digit_in;
   logic [7:0]       digit_timer_ff, digit_timer_in;

   logic             step;
   logic             out_full;
   logic [7:0]       deb_limit, dig_limit, deb_next, timer_next;
   logic [3:0]       row_mask, drive, key;
   logic             key_valid;
   logic [3:0]       lit4;
   logic [7:0]       sel;
   rsp_type          rsp_new;
   logic [RSP_W-1:0] rsp_bits;

   // One sample is executed whenever one waits and the result queue has room.
   assign step    = !cls_empty && !out_full;
   assign cls_pop = step;

   // A zero limit behaves like one.
   assign deb_limit  = (debounce_ticks_ff == 8'd0) ? 8'd1 : debounce_ticks_ff;
   assign dig_limit  = (digit_ticks_ff == 8'd0) ? 8'd1 : digit_ticks_ff;
   assign deb_next   = deb_count_ff + 8'd1;
   assign timer_next = digit_timer_ff + 8'd1;
   assign row_mask   = ~(4'b0001 << scan_row_ff);

   always_comb begin
      phase_in      = phase_ff;
      scan_row_in   = scan_row_ff;
      deb_count_in  = deb_count_ff;
      cap_single_in = cap_single_ff;
      cap_idx_in    = cap_idx_ff;
      drive         = 4'h0;
      key_valid     = 1'b0;
      key           = 4'h0;
      case (phase_ff)
         PH_IDLE: begin
            if (cls_item.any_low) begin
               deb_count_in = 8'd0;
               phase_in     = PH_PRESS_DEB;
            end
         end
         PH_PRESS_DEB: begin
            deb_count_in = deb_next;
            if (deb_next >= deb_limit) begin
               phase_in = PH_CONFIRM;
            end
         end
         PH_CONFIRM: begin
            if (cls_item.any_low) begin
               scan_row_in = 2'd0;
               phase_in    = PH_SCAN;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_SCAN: begin
            drive = row_mask;
            if (cls_item.any_low) begin
               cap_single_in = cls_item.single_low;
               cap_idx_in    = cls_item.col_idx;
               phase_in      = PH_WAIT_REL;
            end else if (scan_row_ff == 2'd3) begin
               scan_row_in = 2'd0;
               phase_in    = PH_IDLE;
            end else begin
               scan_row_in = scan_row_ff + 2'd1;
            end
         end
         PH_WAIT_REL: begin
            drive = row_mask;
            if (!cls_item.any_low) begin
               deb_count_in = 8'd0;
               phase_in     = PH_REL_DEB;
            end
         end
         PH_REL_DEB: begin
            drive        = row_mask;
            deb_count_in = deb_next;
            if (deb_next >= deb_limit) begin
               phase_in = PH_WAIT_REL2;
            end
         end
         PH_WAIT_REL2: begin
            drive = row_mask;
            if (!cls_item.any_low) begin
               if (cap_single_ff) begin
                  key_valid = 1'b1;
                  key       = {~cap_idx_ff, scan_row_ff};
               end
               scan_row_in = 2'd0;
               phase_in    = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Digit multiplexing.
   always_comb begin
      digit_timer_in = timer_next;
      lit_digit_in   = lit_digit_ff;
      if (timer_next >= dig_limit) begin
         digit_timer_in = 8'd0;
         lit_digit_in   = (lit_digit_ff == LIT_W'(DIGITS - 1)) ? '0 : lit_digit_ff + 1'b1;
      end
   end

   assign lit4 = 4'(lit_digit_ff);
   assign sel  = lit4[3] ? 8'hff : ~(8'h01 << lit4[2:0]);

   always_comb begin
      rsp_new.row_drive    = drive;
      rsp_new.digit_select = sel;
      rsp_new.segments     = digit_buf_ff[lit_digit_ff];
      rsp_new.key_valid    = key_valid;
      rsp_new.key_value    = key;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RESET;
         digit_ticks_ff    <= DIGIT_RESET;
      end else if (csr_wr.en) begin
         case (csr_wr.index)
            CSR_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_wr.data;
            CSR_DIGIT_TICKS:    digit_ticks_ff    <= csr_wr.data;
            default:            digit_ticks_ff    <= digit_ticks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         scan_row_ff    <= 2'd0;
         deb_count_ff   <= 8'd0;
         cap_single_ff  <= 1'b0;
         cap_idx_ff     <= 2'd0;
         lit_digit_ff   <= '0;
         digit_timer_ff <= 8'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         scan_row_ff    <= scan_row_in;
         deb_count_ff   <= deb_count_in;
         cap_single_ff  <= cap_single_in;
         cap_idx_ff     <= cap_idx_in;
         lit_digit_ff   <= lit_digit_in;
         digit_timer_ff <= digit_timer_in;
      end
   end

   // Entry buffer: keys shift in from the right; the key after a full
   // buffer blanks it and restarts the count.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         for (int j = 0; j < DIGITS; j++) begin
            digit_buf_ff[j] <= 8'h00;
         end
      end else if (step && key_valid) begin
         if (entry_count_ff == CNT_W'(DIGITS)) begin
            entry_count_ff <= '0;
            for (int j = 0; j < DIGITS; j++) begin
               digit_buf_ff[j] <= 8'h00;
            end
         end else begin
            entry_count_ff <= entry_count_ff + 1'b1;
            for (int j = 0; j < DIGITS - 1; j++) begin
               digit_buf_ff[j] <= digit_buf_ff[j + 1];
            end
            digit_buf_ff[DIGITS - 1] <= seg_code(key);
         end
      end
   end

   kse_queue #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (step),
      .wdata (rsp_new),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

   assign rsp_item = rsp_type'(rsp_bits);

`ifndef SYNTHESIS
   // The row counter only moves while scanning or releasing.
   a_row_zero_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE || phase_ff == PH_PRESS_DEB || phase_ff == PH_CONFIRM)
      |-> (scan_row_ff == 2'd0))
      else $error("scan row not cleared outside the scan");

   // A reported key always comes with exactly one row driven low.
   a_key_row: assert property (@(posedge clock) disable iff (reset)
      (step && key_valid) |-> ($countones(drive) == 3))
      else $error("key reported without a single driven row");

   // The lit digit stays inside the buffer.
   a_lit_range: assert property (@(posedge clock) disable iff (reset)
      lit_digit_ff <= LIT_W'(DIGITS - 1))
      else $error("lit digit out of range");

   // The entry count never passes the buffer size.
   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(DIGITS))
      else $error("entry count out of range");

   // Without a sample to execute, the sequencer holds its state.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(lit_digit_ff))
      else $error("state moved without a sample");
`endif

endmodule
